### rtl/eips_pkg.sv
`timescale 1ns / 1ps
// Package for the external interrupt priority select block.
// Holds beat types, action and source codes, register indexes and shared structs.
package eips_pkg;

	localparam int MAX_CPUS_DEF = 64;

	// Action codes of an input beat.
	localparam logic [2:0] ACT_TAKE     = 3'd0;
	localparam logic [2:0] ACT_KEY      = 3'd1;
	localparam logic [2:0] ACT_MALFUNC  = 3'd2;
	localparam logic [2:0] ACT_EMERG    = 3'd3;
	localparam logic [2:0] ACT_CALL     = 3'd4;
	localparam logic [2:0] ACT_SERVICE  = 3'd5;
	localparam logic [2:0] ACT_INTERVAL = 3'd6;

	// Interrupt source codes, highest priority first.
	localparam logic [2:0] SRC_KEY      = 3'd0;
	localparam logic [2:0] SRC_MALFUNC  = 3'd1;
	localparam logic [2:0] SRC_EMERG    = 3'd2;
	localparam logic [2:0] SRC_CALL     = 3'd3;
	localparam logic [2:0] SRC_CLKCMP   = 3'd4;
	localparam logic [2:0] SRC_TIMER    = 3'd5;
	localparam logic [2:0] SRC_INTERVAL = 3'd6;
	localparam logic [2:0] SRC_SERVICE  = 3'd7;

	// Configuration register indexes.
	localparam logic [1:0] REG_CPU_COUNT = 2'd0;
	localparam logic [1:0] REG_CLOCK_CMP = 2'd1;
	localparam logic [1:0] REG_PREFIX    = 2'd2;

	typedef struct packed {
		logic [2:0]         action;
		logic [5:0]         cpu_addr;
		logic [31:0]        service_parm;
		logic [7:0]         enable_mask;
		logic               guest_mode;
		logic [63:0]        tod_value;
		logic signed [63:0] cpu_timer_value;
	} in_item_t;

	typedef struct packed {
		logic        taken;
		logic [2:0]  int_source;
		logic [5:0]  source_cpu;
		logic [31:0] interrupt_parm;
	} out_item_t;

	// Single-bit pending sources and their kept values.
	typedef struct packed {
		logic        key;
		logic        call;
		logic [5:0]  call_sender;
		logic        interval;
		logic        service;
		logic [31:0] service_value;
	} pend_t;

	// Outcome of the priority selection for one take beat.
	typedef struct packed {
		logic        hit;
		logic [2:0]  int_source;
		logic [5:0]  source_cpu;
		logic [31:0] interrupt_parm;
	} dec_t;

endpackage

### rtl/eips_arb.sv
`timescale 1ns / 1ps
// Priority selection among pending external sources for one take beat.
// Purely combinational; uses types and codes from eips_pkg.
module eips_arb #(
	parameter int MAX_CPUS = eips_pkg::MAX_CPUS_DEF
) (
	input  eips_pkg::in_item_t    item,
	input  eips_pkg::pend_t       pend,
	input  logic [MAX_CPUS-1:0]   mal_srch,
	input  logic [MAX_CPUS-1:0]   emg_srch,
	input  logic [63:0]           clock_comparator,
	input  logic [19:0]           prefix_page,
	output eips_pkg::dec_t        dec,
	output logic [MAX_CPUS-1:0]   win_onehot
);

	logic [MAX_CPUS-1:0] mal_oh;
	logic [MAX_CPUS-1:0] emg_oh;
	logic [5:0]          mal_idx;
	logic [5:0]          emg_idx;
	logic                is_take;
	logic                clk_hit;
	logic [31:0]         svc_parm;

	// Isolate the lowest set bit: the lowest CPU address wins.
	assign mal_oh = mal_srch & (~mal_srch + {{(MAX_CPUS-1){1'b0}}, 1'b1});
	assign emg_oh = emg_srch & (~emg_srch + {{(MAX_CPUS-1){1'b0}}, 1'b1});

	always_comb begin
		mal_idx = '0;
		emg_idx = '0;
		for (int i = 0; i < MAX_CPUS; i++) begin
			if (mal_oh[i]) begin
				mal_idx = mal_idx | 6'(i);
			end
			if (emg_oh[i]) begin
				emg_idx = emg_idx | 6'(i);
			end
		end
	end

	assign is_take = (item.action == eips_pkg::ACT_TAKE);
	assign clk_hit = (item.tod_value > clock_comparator);

	// A parameter with any of bits 31:3 set is swapped between page zero and the prefix page; other pages pass unchanged.
	always_comb begin
		svc_parm = pend.service_value;
		if (pend.service_value[31:3] != '0) begin
			if (pend.service_value[31:12] == '0) begin
				svc_parm = {prefix_page, pend.service_value[11:0]};
			end else if (pend.service_value[31:12] == prefix_page) begin
				svc_parm = {20'b0, pend.service_value[11:0]};
			end
		end
	end

	always_comb begin
		dec = '0;
		dec.hit = is_take;
		if (pend.key && item.enable_mask[0] && !item.guest_mode) begin
			dec.int_source = eips_pkg::SRC_KEY;
		end else if ((mal_srch != '0) && item.enable_mask[1]) begin
			dec.int_source = eips_pkg::SRC_MALFUNC;
			dec.source_cpu = mal_idx;
		end else if ((emg_srch != '0) && item.enable_mask[2]) begin
			dec.int_source = eips_pkg::SRC_EMERG;
			dec.source_cpu = emg_idx;
		end else if (pend.call && item.enable_mask[3]) begin
			dec.int_source = eips_pkg::SRC_CALL;
			dec.source_cpu = pend.call_sender;
		end else if (clk_hit && item.enable_mask[4]) begin
			dec.int_source = eips_pkg::SRC_CLKCMP;
		end else if (item.cpu_timer_value[63] && item.enable_mask[5]) begin
			dec.int_source = eips_pkg::SRC_TIMER;
		end else if (pend.interval && item.enable_mask[6]) begin
			dec.int_source = eips_pkg::SRC_INTERVAL;
		end else if (pend.service && item.enable_mask[7] && !item.guest_mode) begin
			dec.int_source = eips_pkg::SRC_SERVICE;
			dec.interrupt_parm = svc_parm;
		end else begin
			dec.hit = 1'b0;
		end
	end

	assign win_onehot = (dec.int_source == eips_pkg::SRC_MALFUNC) ? mal_oh : emg_oh;

endmodule

### rtl/eips_regs.sv
`timescale 1ns / 1ps
// Configuration registers and pending-source state of the interrupt select block.
// Applies posts and take clears for each processed beat; uses eips_pkg.
module eips_regs #(
	parameter int MAX_CPUS = eips_pkg::MAX_CPUS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [63:0]           cfg_data,
	input  logic                  fire,
	input  eips_pkg::in_item_t    item,
	input  eips_pkg::dec_t        dec,
	input  logic [MAX_CPUS-1:0]   win_onehot,
	output eips_pkg::pend_t       pend,
	output logic [MAX_CPUS-1:0]   mal_srch,
	output logic [MAX_CPUS-1:0]   emg_srch,
	output logic [63:0]           clock_comparator,
	output logic [19:0]           prefix_page
);

	logic [6:0]          cpu_count_q;
	logic [63:0]         clock_cmp_q;
	logic [19:0]         prefix_page_q;
	logic [MAX_CPUS-1:0] mal_bits_q;
	logic [MAX_CPUS-1:0] emg_bits_q;
	eips_pkg::pend_t     pend_q;
	logic [MAX_CPUS-1:0] search_mask;
	logic [MAX_CPUS-1:0] cpu_dec;

	// Counts above the bitmap width enable every bit, so no saturation is needed.
	always_comb begin
		for (int i = 0; i < MAX_CPUS; i++) begin
			search_mask[i] = (cpu_count_q > 7'(i));
			cpu_dec[i]     = (item.cpu_addr == 6'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_count_q   <= 7'd1;
			clock_cmp_q   <= '0;
			prefix_page_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				eips_pkg::REG_CPU_COUNT: cpu_count_q   <= cfg_data[6:0];
				eips_pkg::REG_CLOCK_CMP: clock_cmp_q   <= cfg_data;
				eips_pkg::REG_PREFIX:    prefix_page_q <= cfg_data[31:12];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mal_bits_q <= '0;
			emg_bits_q <= '0;
			pend_q     <= '0;
		end else if (fire) begin
			unique case (item.action)
				eips_pkg::ACT_TAKE: begin
					if (dec.hit) begin
						case (dec.int_source)
							eips_pkg::SRC_KEY:      pend_q.key <= 1'b0;
							eips_pkg::SRC_MALFUNC:  mal_bits_q <= mal_bits_q & ~win_onehot;
							eips_pkg::SRC_EMERG:    emg_bits_q <= emg_bits_q & ~win_onehot;
							eips_pkg::SRC_CALL:     pend_q.call <= 1'b0;
							eips_pkg::SRC_INTERVAL: pend_q.interval <= 1'b0;
							eips_pkg::SRC_SERVICE: begin
								pend_q.service       <= 1'b0;
								pend_q.service_value <= '0;
							end
							default: ;
						endcase
					end
				end
				eips_pkg::ACT_KEY:     pend_q.key <= 1'b1;
				eips_pkg::ACT_MALFUNC: mal_bits_q <= mal_bits_q | cpu_dec;
				eips_pkg::ACT_EMERG:   emg_bits_q <= emg_bits_q | cpu_dec;
				eips_pkg::ACT_CALL: begin
					pend_q.call        <= 1'b1;
					pend_q.call_sender <= item.cpu_addr;
				end
				eips_pkg::ACT_SERVICE: begin
					pend_q.service       <= 1'b1;
					pend_q.service_value <= item.service_parm;
				end
				eips_pkg::ACT_INTERVAL: pend_q.interval <= 1'b1;
				default: ;
			endcase
		end
	end

	assign pend             = pend_q;
	assign mal_srch         = mal_bits_q & search_mask;
	assign emg_srch         = emg_bits_q & search_mask;
	assign clock_comparator = clock_cmp_q;
	assign prefix_page      = prefix_page_q;

	// Taking a malfunction alert removes exactly one sender bit.
	a_mal_clear_one: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.action == eips_pkg::ACT_TAKE && dec.hit &&
		dec.int_source == eips_pkg::SRC_MALFUNC
		|=> $countones(mal_bits_q) == $countones($past(mal_bits_q)) - 1)
		else $error("malfunction take did not clear exactly one bit");

	a_key_post: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.action == eips_pkg::ACT_KEY |=> pend_q.key)
		else $error("key post not recorded");

endmodule

### rtl/external_interrupt_priority_select_core.sv
`timescale 1ns / 1ps
// Top level of the external interrupt priority select block.
// Depends on eips_pkg, eips_regs and eips_arb.
//
//   Port group   Direction  Handshake           Beat
//   in_*         input      in_valid/in_stall   eips_pkg::in_item_t
//   out_*        output     out_valid/out_stall eips_pkg::out_item_t
//   cfg_*        input      cfg_we              index and 64-bit data
//
// Each beat is held in the input register, where selection and state
// update happen, then a take that finds a source sits in the result register.
// Sustained rate is one beat per cycle while a stalled result does not hold the input register.
// Reset clears all pending sources and sets the CPU count to one.
// A stalled result holds the input register only when that beat also yields a result.
module external_interrupt_priority_select_core #(
	parameter int MAX_CPUS = eips_pkg::MAX_CPUS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  eips_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output eips_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_data
);

	eips_pkg::in_item_t  item_s1;
	logic                valid_s1;
	eips_pkg::out_item_t res_s2;
	logic                res_valid_s2;

	eips_pkg::pend_t     pend;
	eips_pkg::dec_t      dec;
	logic [MAX_CPUS-1:0] mal_srch;
	logic [MAX_CPUS-1:0] emg_srch;
	logic [MAX_CPUS-1:0] win_onehot;
	logic [63:0]         clock_comparator;
	logic [19:0]         prefix_page;
	logic                out_free;
	logic                fire;

	assign out_free = !res_valid_s2 || !out_stall;
	assign fire     = valid_s1 && (out_free || !dec.hit);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (out_free) begin
			res_valid_s2 <= fire && dec.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire && dec.hit) begin
			res_s2.taken          <= 1'b1;
			res_s2.int_source     <= dec.int_source;
			res_s2.source_cpu     <= dec.source_cpu;
			res_s2.interrupt_parm <= dec.interrupt_parm;
		end
	end

	assign out_valid = res_valid_s2;
	assign out_data  = res_s2;

	eips_regs #(
		.MAX_CPUS(MAX_CPUS)
	) u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.fire             (fire),
		.item             (item_s1),
		.dec              (dec),
		.win_onehot       (win_onehot),
		.pend             (pend),
		.mal_srch         (mal_srch),
		.emg_srch         (emg_srch),
		.clock_comparator (clock_comparator),
		.prefix_page      (prefix_page)
	);

	eips_arb #(
		.MAX_CPUS(MAX_CPUS)
	) u_arb (
		.item             (item_s1),
		.pend             (pend),
		.mal_srch         (mal_srch),
		.emg_srch         (emg_srch),
		.clock_comparator (clock_comparator),
		.prefix_page      (prefix_page),
		.dec              (dec),
		.win_onehot       (win_onehot)
	);

	a_taken_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.taken)
		else $error("result beat without taken flag");

	a_parm_only_service: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.int_source != eips_pkg::SRC_SERVICE
		|-> out_data.interrupt_parm == '0)
		else $error("parameter on a non-service result");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && dec.hit && res_valid_s2 && out_stall |-> in_stall)
		else $error("selecting beat advanced into a full result register");

	a_hit_only_take: assert property (@(posedge clk) disable iff (!arst_n)
		dec.hit |-> item_s1.action == eips_pkg::ACT_TAKE)
		else $error("selection reported for a post beat");

endmodule
